// ----- src/afac_pkg.sv -----
package afac_pkg;

  localparam logic [2:0] FUNC_START  = 3'd0;
  localparam logic [2:0] FUNC_PIXEL  = 3'd1;
  localparam logic [2:0] FUNC_READ   = 3'd2;
  localparam logic [2:0] FUNC_FINISH = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [2:0] DISP_CLEAR_RECT = 3'd2;
  localparam logic [2:0] DISP_RESTORE    = 3'd3;

  localparam logic [0:0] CFG_WIDTH  = 1'd0;
  localparam logic [0:0] CFG_HEIGHT = 1'd1;

  localparam logic [8:0] CANVAS_RESET = 9'd256;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] frame_left;
    logic [15:0] frame_top;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [2:0]  disposal;
    logic [7:0]  pix_blue;
    logic [7:0]  pix_green;
    logic [7:0]  pix_red;
    logic [7:0]  pix_alpha;
    logic [7:0]  read_x;
    logic [7:0]  read_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } out_item_t;

endpackage

// ----- src/animated_frame_alpha_compositor.sv -----
// read: the result is strobed in the cycle after the read is accepted, then ready again
// source pixel: when drawn, the canvas read, the blend multiply and the divide and
// write back follow in turn; a skipped pixel leaves the block idle; start/finish/clear
// may walk: all entries for clear, snapshot and restore (copy ends in its own state), clipped w*h
// reset: busy while every canvas memory entry is zeroed
// the receiver cannot stall: out_valid lasts exactly one cycle
module animated_frame_alpha_compositor #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  afac_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output afac_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [8:0]           cfg_data
);
  import afac_pkg::*;

  localparam int N   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = $clog2(N);
  localparam int CWB = $clog2(MAX_WIDTH + 1);
  localparam int RWB = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PIX_MUL, S_PIX_WR, S_RDOUT, S_COPY, S_COPY_END, S_RECT, S_ZERO
  } state_t;

  state_t          state_r;
  logic [8:0]      cwidth_r, cheight_r;
  logic [15:0]     cur_left_r, cur_top_r, cur_width_r, cur_height_r;
  logic [2:0]      cur_disp_r;
  logic [15:0]     src_col_r, src_row_r;
  logic [AW-1:0]   cnt_r, pend_addr_r, addr_r, row_addr_r;
  logic            pend_r, copy_dir_r, rd_ok_r;
  logic [CWB-1:0]  col_r, w_r;
  logic [RWB-1:0]  row_r, h_r;
  logic [7:0]      pb_r, pg_r, pr_r, pa_r;
  logic [15:0]     sb_r, sg_r, sr_r;

  logic [31:0]     canvas_mem [N];
  logic [31:0]     saved_mem  [N];
  logic [31:0]     canvas_rd_q, saved_rd_q;
  logic [AW-1:0]   canvas_raddr, canvas_waddr;
  logic [31:0]     canvas_wdata;
  logic            canvas_we;

  logic            accept;
  logic [15:0]     ecw, ech;
  logic            visible, advance, draw, rd_in;
  logic [16:0]     col_inc;
  logic [AW-1:0]   pix_addr, rd_addr;
  logic [15:0]     rect_w, rect_h;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign ecw = (16'(cwidth_r) > 16'(MAX_WIDTH))   ? 16'(MAX_WIDTH)  : 16'(cwidth_r);
  assign ech = (16'(cheight_r) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(cheight_r);

  assign visible = (ecw != '0) && (ech != '0) && (cur_width_r != '0) &&
                   (cur_height_r != '0) && (cur_left_r < ecw) && (cur_top_r < ech);
  assign advance = (cur_width_r != '0) && (src_row_r < cur_height_r);
  assign col_inc = {1'b0, src_col_r} + 17'd1;
  assign draw    = advance && visible && (src_col_r < ecw - cur_left_r) &&
                   (src_row_r < ech - cur_top_r) && (in_item.pix_alpha != '0);
  assign pix_addr = AW'((32'(cur_top_r) + 32'(src_row_r)) * MAX_WIDTH +
                        32'(cur_left_r) + 32'(src_col_r));
  assign rd_in   = (16'(in_item.read_x) < ecw) && (16'(in_item.read_y) < ech);
  assign rd_addr = AW'(32'(in_item.read_y) * MAX_WIDTH + 32'(in_item.read_x));
  assign rect_w  = (cur_width_r < ecw - cur_left_r) ? cur_width_r : ecw - cur_left_r;
  assign rect_h  = (cur_height_r < ech - cur_top_r) ? cur_height_r : ech - cur_top_r;

  assign canvas_raddr = (state_r == S_COPY) ? cnt_r :
                        (in_item.func == FUNC_READ) ? rd_addr : pix_addr;

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

  always_comb begin
    canvas_we    = 1'b0;
    canvas_waddr = cnt_r;
    canvas_wdata = '0;
    unique case (state_r)
      S_INIT, S_ZERO: canvas_we = 1'b1;
      S_RECT: begin
        canvas_we    = 1'b1;
        canvas_waddr = row_addr_r + AW'(col_r);
      end
      S_PIX_WR: begin
        canvas_we    = 1'b1;
        canvas_waddr = addr_r;
        canvas_wdata = {ALPHA_OPAQUE, div255(sr_r), div255(sg_r), div255(sb_r)};
      end
      default: begin
        canvas_we    = pend_r && copy_dir_r;
        canvas_waddr = pend_addr_r;
        canvas_wdata = saved_rd_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (canvas_we) begin
      canvas_mem[canvas_waddr] <= canvas_wdata;
    end
    canvas_rd_q <= canvas_mem[canvas_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend_r && !copy_dir_r) begin
      saved_mem[pend_addr_r] <= canvas_rd_q;
    end
    saved_rd_q <= saved_mem[cnt_r];
  end

  // blend products, alpha 255 falls out of the same sum exactly
  always_ff @(posedge clk) begin
    if (state_r == S_PIX_MUL) begin
      sb_r <= 16'(pb_r) * 16'(pa_r) + 16'(canvas_rd_q[7:0])   * 16'(ALPHA_OPAQUE - pa_r);
      sg_r <= 16'(pg_r) * 16'(pa_r) + 16'(canvas_rd_q[15:8])  * 16'(ALPHA_OPAQUE - pa_r);
      sr_r <= 16'(pr_r) * 16'(pa_r) + 16'(canvas_rd_q[23:16]) * 16'(ALPHA_OPAQUE - pa_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cwidth_r     <= CANVAS_RESET;
      cheight_r    <= CANVAS_RESET;
      cur_left_r   <= '0;
      cur_top_r    <= '0;
      cur_width_r  <= '0;
      cur_height_r <= '0;
      cur_disp_r   <= '0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      copy_dir_r   <= 1'b0;
      rd_ok_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIDTH:  cwidth_r  <= cfg_data;
          CFG_HEIGHT: cheight_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_INIT, S_ZERO: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == AW'(N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            unique case (in_item.func)
              FUNC_START: begin
                cur_left_r   <= in_item.frame_left;
                cur_top_r    <= in_item.frame_top;
                cur_width_r  <= in_item.frame_width;
                cur_height_r <= in_item.frame_height;
                cur_disp_r   <= in_item.disposal;
                src_col_r    <= '0;
                src_row_r    <= '0;
                if (in_item.disposal == DISP_RESTORE) begin
                  copy_dir_r <= 1'b0;
                  state_r    <= S_COPY;
                end
              end
              FUNC_PIXEL: begin
                if (advance) begin
                  if (col_inc >= {1'b0, cur_width_r}) begin
                    src_col_r <= '0;
                    src_row_r <= src_row_r + 16'd1;
                  end else begin
                    src_col_r <= col_inc[15:0];
                  end
                end
                if (draw) begin
                  addr_r  <= pix_addr;
                  pb_r    <= in_item.pix_blue;
                  pg_r    <= in_item.pix_green;
                  pr_r    <= in_item.pix_red;
                  pa_r    <= in_item.pix_alpha;
                  state_r <= S_PIX_MUL;
                end
              end
              FUNC_READ: begin
                rd_ok_r <= rd_in;
                state_r <= S_RDOUT;
              end
              FUNC_FINISH: begin
                if (cur_disp_r == DISP_CLEAR_RECT && visible) begin
                  w_r        <= CWB'(rect_w);
                  h_r        <= RWB'(rect_h);
                  col_r      <= '0;
                  row_r      <= '0;
                  row_addr_r <= AW'(32'(cur_top_r) * MAX_WIDTH + 32'(cur_left_r));
                  state_r    <= S_RECT;
                end else if (cur_disp_r == DISP_RESTORE) begin
                  copy_dir_r <= 1'b1;
                  state_r    <= S_COPY;
                end
              end
              FUNC_CLEAR: state_r <= S_ZERO;
              default: ;
            endcase
          end
        end
        S_PIX_MUL: state_r <= S_PIX_WR;
        S_PIX_WR:  state_r <= S_IDLE;
        S_RDOUT:   state_r <= S_IDLE;
        // read one entry a cycle, write it back in the following cycle
        S_COPY: begin
          pend_r      <= 1'b1;
          pend_addr_r <= cnt_r;
          cnt_r       <= cnt_r + 1'b1;
          if (cnt_r == AW'(N - 1)) begin
            state_r <= S_COPY_END;
          end
        end
        S_COPY_END: begin
          pend_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        S_RECT: begin
          if (col_r == w_r - 1'b1) begin
            col_r      <= '0;
            row_r      <= row_r + 1'b1;
            row_addr_r <= row_addr_r + AW'(MAX_WIDTH);
            if (row_r == h_r - 1'b1) begin
              state_r <= S_IDLE;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state_r == S_RDOUT);
  assign out_item  = rd_ok_r ? out_item_t'(
                       {canvas_rd_q[7:0], canvas_rd_q[15:8],
                        canvas_rd_q[23:16], canvas_rd_q[31:24]}) : '0;

  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept) && $past(in_item.func) == FUNC_READ)
    else $error("result without a read item");

  a_out_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !pend_r)
    else $error("copy write still pending while idle");

endmodule

// ----- verif/animated_frame_alpha_compositor_tb.sv -----
`timescale 1ns / 1ps

module animated_frame_alpha_compositor_tb;
  import afac_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_WIDTH;
  logic [8:0] cfg_data = '0;

  animated_frame_alpha_compositor #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // canvas predictor state
  logic [31:0] canvas_px [MAXW*MAXH];
  logic [31:0] snap_px [MAXW*MAXH];
  int unsigned canvas_w, canvas_h;
  int unsigned fr_left, fr_top, fr_width, fr_height, fr_disp;
  int unsigned next_col, next_row;

  out_item_t expected_pixels[$];
  int fail_count = 0;
  int idle_pct = 0;
  int items_sent = 0;
  int walks_left = 0;

  function automatic int unsigned eff_w();
    return canvas_w > MAXW ? MAXW : canvas_w;
  endfunction

  function automatic int unsigned eff_h();
    return canvas_h > MAXH ? MAXH : canvas_h;
  endfunction

  function automatic bit frame_on_canvas();
    return eff_w() != 0 && eff_h() != 0 && fr_width != 0 && fr_height != 0 &&
           fr_left < eff_w() && fr_top < eff_h();
  endfunction

  function automatic logic [7:0] mix(int unsigned s, int unsigned d, int unsigned a);
    return 8'((s * a + d * (255 - a)) / 255);
  endfunction

  task automatic draw_pixel(in_item_t it);
    int unsigned x, y, idx;
    logic [31:0] d;
    x = next_col;
    y = next_row;
    if (fr_width == 0 || next_row >= fr_height) return;
    next_col++;
    if (next_col >= fr_width) begin
      next_col = 0;
      next_row++;
    end
    if (!frame_on_canvas()) return;
    if (x >= eff_w() - fr_left || y >= eff_h() - fr_top) return;
    idx = (fr_top + y) * MAXW + fr_left + x;
    d = canvas_px[idx];
    if (it.pix_alpha == 0) return;
    if (it.pix_alpha == ALPHA_OPAQUE)
      canvas_px[idx] = {it.pix_alpha, it.pix_red, it.pix_green, it.pix_blue};
    else
      canvas_px[idx] = {8'hff, mix(32'(it.pix_red), 32'(d[23:16]), 32'(it.pix_alpha)),
                        mix(32'(it.pix_green), 32'(d[15:8]), 32'(it.pix_alpha)),
                        mix(32'(it.pix_blue), 32'(d[7:0]), 32'(it.pix_alpha))};
  endtask

  task automatic apply_item(in_item_t it);
    int unsigned w, h;
    logic [31:0] p;
    out_item_t e;
    case (it.func)
      FUNC_START: begin
        fr_left = 32'(it.frame_left);
        fr_top = 32'(it.frame_top);
        fr_width = 32'(it.frame_width);
        fr_height = 32'(it.frame_height);
        fr_disp = 32'(it.disposal);
        next_col = 0;
        next_row = 0;
        if (it.disposal == DISP_RESTORE) snap_px = canvas_px;
      end
      FUNC_PIXEL: draw_pixel(it);
      FUNC_READ: begin
        p = '0;
        if (it.read_x < eff_w() && it.read_y < eff_h())
          p = canvas_px[32'(it.read_y) * MAXW + 32'(it.read_x)];
        e = '{p[7:0], p[15:8], p[23:16], p[31:24]};
        expected_pixels = {expected_pixels, e};
      end
      FUNC_FINISH: begin
        if (fr_disp == DISP_CLEAR_RECT && frame_on_canvas()) begin
          w = fr_width < eff_w() - fr_left ? fr_width : eff_w() - fr_left;
          h = fr_height < eff_h() - fr_top ? fr_height : eff_h() - fr_top;
          for (int yy = 0; yy < h; yy++)
            for (int xx = 0; xx < w; xx++)
              canvas_px[(fr_top + yy) * MAXW + fr_left + xx] = '0;
        end else if (fr_disp == DISP_RESTORE) begin
          canvas_px = snap_px;
        end
      end
      FUNC_CLEAR: foreach (canvas_px[i]) canvas_px[i] = '0;
      default: ;
    endcase
  endtask

  // every field random, func forced
  function automatic in_item_t rand_item(logic [2:0] f);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    it.func = f;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_item(it);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [8:0] val);
    settle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) canvas_w = 32'(val);
    else canvas_h = 32'(val);
  endtask

  task automatic send_start(int l, int t, int w, int h, int disp);
    in_item_t it;
    it = rand_item(FUNC_START);
    it.frame_left = 16'(l);
    it.frame_top = 16'(t);
    it.frame_width = 16'(w);
    it.frame_height = 16'(h);
    it.disposal = 3'(disp);
    send_item(it);
  endtask

  task automatic send_pixel(int b, int g, int r, int a);
    in_item_t it;
    it = rand_item(FUNC_PIXEL);
    it.pix_blue = 8'(b);
    it.pix_green = 8'(g);
    it.pix_red = 8'(r);
    it.pix_alpha = 8'(a);
    send_item(it);
  endtask

  task automatic send_read(int x, int y);
    in_item_t it;
    it = rand_item(FUNC_READ);
    it.read_x = 8'(x);
    it.read_y = 8'(y);
    send_item(it);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result %h", out_item);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_item.out_blue !== want.out_blue) begin
          $error("out_blue expected %h actual %h", want.out_blue, out_item.out_blue);
          fail_count++;
        end
        if (out_item.out_green !== want.out_green) begin
          $error("out_green expected %h actual %h", want.out_green, out_item.out_green);
          fail_count++;
        end
        if (out_item.out_red !== want.out_red) begin
          $error("out_red expected %h actual %h", want.out_red, out_item.out_red);
          fail_count++;
        end
        if (out_item.out_alpha !== want.out_alpha) begin
          $error("out_alpha expected %h actual %h", want.out_alpha, out_item.out_alpha);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct = 8;
    send_start(0, 0, 2, 2, 0);
    send_pixel(8'hff, 8'h00, 8'hff, 255);
    send_pixel(8'h12, 8'h34, 8'h56, 0);
    send_pixel(8'h00, 8'hff, 8'h80, 128);
    send_pixel(8'hff, 8'hff, 8'hff, 1);
    send_pixel(8'haa, 8'hbb, 8'hcc, 255);
    send_read(0, 0);
    send_read(0, 1);
    send_read(255, 255);
    send_item(rand_item(3'd5));
    send_item(rand_item(3'd6));
    send_item(rand_item(3'd7));
    // frame off canvas, clear rectangle does nothing
    send_start(300, 0, 4, 4, DISP_CLEAR_RECT);
    send_item(rand_item(FUNC_FINISH));
    // snapshot, draw, restore twice
    send_start(254, 254, 65535, 65535, DISP_RESTORE);
    send_pixel(1, 2, 3, 255);
    send_read(254, 254);
    send_item(rand_item(FUNC_FINISH));
    send_item(rand_item(FUNC_FINISH));
    send_read(254, 254);
    send_read(1, 0);
    send_item(rand_item(FUNC_CLEAR));
    send_read(0, 0);
    // tiny and empty canvases, read outside canvas
    write_cfg(CFG_WIDTH, 9'd1);
    write_cfg(CFG_HEIGHT, 9'd1);
    send_start(0, 0, 3, 1, DISP_CLEAR_RECT);
    send_pixel(9, 8, 7, 255);
    send_pixel(9, 8, 7, 255);
    send_read(0, 0);
    send_read(1, 0);
    send_item(rand_item(FUNC_FINISH));
    send_read(0, 0);
    write_cfg(CFG_WIDTH, 9'd0);
    send_read(0, 0);
  endtask

  task automatic frame_sequence();
    int l, t, w, h, disp, npix, cw;
    longint area;
    cw = eff_w() == 0 ? 1 : eff_w();
    l = $urandom_range(0, cw + 3);
    t = $urandom_range(0, (eff_h() == 0 ? 1 : eff_h()) + 3);
    w = $urandom_range(0, 8);
    h = $urandom_range(0, 8);
    if ($urandom_range(19) == 0) begin
      l = $urandom_range(0, 65535);
      t = $urandom_range(0, 65535);
    end
    if ($urandom_range(29) == 0) begin
      w = $urandom_range(0, 65535);
      h = $urandom_range(0, 65535);
    end
    area = longint'(w) * longint'(h);
    do disp = $urandom_range(0, 7); while (disp == DISP_RESTORE);
    if (walks_left >= 2 && $urandom_range(14) == 0) begin
      disp = DISP_RESTORE;
      walks_left -= 2;
    end
    // large clipped rectangle clears are as slow as a walk
    if (disp == DISP_CLEAR_RECT && area > 4096) disp = 0;
    send_start(l, t, w, h, disp);
    npix = (area > 64) ? $urandom_range(1, 64) : int'(area);
    case ($urandom_range(9))
      0: npix = npix / 2;
      1: npix = npix + $urandom_range(1, 3);
      default: ;
    endcase
    for (int i = 0; i < npix; i++) begin
      case ($urandom_range(5))
        0: send_pixel($urandom, $urandom, $urandom, 0);
        1: send_pixel($urandom, $urandom, $urandom, 255);
        default: send_pixel($urandom, $urandom, $urandom, $urandom_range(1, 254));
      endcase
      if ($urandom_range(6) == 0)
        send_read(l + $urandom_range(0, 8), t + $urandom_range(0, 8));
    end
    if ($urandom_range(7) != 0) send_item(rand_item(FUNC_FINISH));
    if (disp != DISP_RESTORE && $urandom_range(9) == 0)
      send_item(rand_item(FUNC_FINISH));
    send_read(l + $urandom_range(0, 8), t + $urandom_range(0, 8));
    send_read($urandom, $urandom);
    if ($urandom_range(11) == 0) send_item(rand_item(3'($urandom_range(5, 7))));
    if (walks_left > 0 && $urandom_range(60) == 0) begin
      walks_left--;
      send_item(rand_item(FUNC_CLEAR));
    end
  endtask

  task automatic test_random(int pct, logic [8:0] w, logic [8:0] h, int n);
    int stop_at;
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
    idle_pct = pct;
    walks_left = 2;
    stop_at = items_sent + n;
    while (items_sent < stop_at) frame_sequence();
  endtask

  initial begin
    foreach (canvas_px[i]) begin
      canvas_px[i] = '0;
      snap_px[i] = '0;
    end
    canvas_w = 32'(CANVAS_RESET);
    canvas_h = 32'(CANVAS_RESET);
    {fr_left, fr_top, fr_width, fr_height, fr_disp, next_col, next_row} = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(8, 9'd37, 9'd29, 580);
    test_random(65, 9'd300, 9'd511, 580);
    test_random(0, 9'd256, 9'd256, 580);
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/afac_pkg.sv
src/animated_frame_alpha_compositor.sv
verif/animated_frame_alpha_compositor_tb.sv
